/* hdl/ffpa_pkg.sv */
// Shared types and constants of the first-fit pool allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package ffpa_pkg;
    localparam int unsigned POOL_BYTES    = 65536;
    localparam int unsigned GRANULE_BYTES = 4;
    localparam int unsigned GL     = $clog2(GRANULE_BYTES);
    localparam int unsigned NGRAN  = POOL_BYTES / GRANULE_BYTES;
    localparam int unsigned GW     = $clog2(NGRAN);      // granule index
    localparam int unsigned LW     = GW + 1;             // link, holds end mark
    localparam int unsigned SW     = $clog2(POOL_BYTES + 1);
    localparam int unsigned EW     = LW + 1;             // block end compare
    localparam int unsigned REQ_W  = 17;
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned WW     = REQ_W + 4;          // rounded request
    localparam int unsigned PW     = 21;                 // pool offset compare

    localparam logic [LW-1:0] LIST_END = LW'(NGRAN);

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NO_MEM  = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_A_WALK, S_A_SPLIT, S_F_WALK, S_F_PGD, S_F_NPD,
        S_F_WNEXT, S_F_WPREV, S_OUT
    } state_t;

    typedef struct packed {
        logic          rd_en;
        logic [GW-1:0] rd_addr;
        logic          sz_we;
        logic [GW-1:0] sz_addr;
        logic [SW-1:0] sz_wdata;
        logic          lk_we;
        logic [GW-1:0] lk_addr;
        logic [LW-1:0] lk_wdata;
    } mem_req_t;

    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] offset;
    } result_t;
endpackage
`default_nettype wire

/* hdl/ffpa_store.sv */
// Block size and next-free link memories with a registered read.
// Depends on ffpa_pkg; entry 0 reads its reset value until first written.
`default_nettype none
module ffpa_store import ffpa_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mem_req_t req,
    output logic [SW-1:0] rd_size,
    output logic [LW-1:0] rd_link
);
    logic [SW-1:0] size_mem [NGRAN];
    logic [LW-1:0] link_mem [NGRAN];
    logic [SW-1:0] size_q_reg;
    logic [LW-1:0] link_q_reg;
    logic          sz0_valid_reg, lk0_valid_reg;
    logic          sz0_dflt_reg, lk0_dflt_reg;

    always_ff @(posedge aclk) begin
        if (req.sz_we) begin
            size_mem[req.sz_addr] <= req.sz_wdata;
        end
        if (req.lk_we) begin
            link_mem[req.lk_addr] <= req.lk_wdata;
        end
        if (req.rd_en) begin
            size_q_reg <= size_mem[req.rd_addr];
            link_q_reg <= link_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sz0_valid_reg <= 1'b0;
            lk0_valid_reg <= 1'b0;
            sz0_dflt_reg  <= 1'b0;
            lk0_dflt_reg  <= 1'b0;
        end else begin
            if (req.sz_we && req.sz_addr == '0) begin
                sz0_valid_reg <= 1'b1;
            end
            if (req.lk_we && req.lk_addr == '0) begin
                lk0_valid_reg <= 1'b1;
            end
            if (req.rd_en) begin
                sz0_dflt_reg <= (req.rd_addr == '0) && !sz0_valid_reg;
                lk0_dflt_reg <= (req.rd_addr == '0) && !lk0_valid_reg;
            end
        end
    end

    assign rd_size = sz0_dflt_reg ? SW'(POOL_BYTES) : size_q_reg;
    assign rd_link = lk0_dflt_reg ? LIST_END : link_q_reg;
endmodule
`default_nettype wire

/* hdl/ffpa_ctrl.sv */
// Request sequencer: walks the free list, splits, merges, writes back.
// Depends on ffpa_pkg; drives ffpa_store through a mem_req_t.
`default_nettype none
module ffpa_ctrl import ffpa_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cmd_t             in_cmd,
    input  wire logic [REQ_W-1:0] in_bytes,
    input  wire logic [OFF_W-1:0] in_off,
    output mem_req_t              req,
    input  wire logic [SW-1:0]    rd_size,
    input  wire logic [LW-1:0]    rd_link_raw,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res
);
    state_t        state_reg, state_next;
    logic [LW-1:0] head_reg, head_next;
    logic          cp_head_reg, cp_head_next;
    logic [GW-1:0] cp_reg, cp_next;
    logic [LW-1:0] np_reg, np_next;
    logic [GW-1:0] pg_reg, pg_next;
    logic [WW-1:0] want_reg, want_next;
    logic [SW-1:0] ps_reg, ps_next, ns_reg, ns_next, cps_reg, cps_next;
    logic [LW-1:0] nl_reg, nl_next;
    result_t       res_reg, res_next;

    logic [LW-1:0] rd_link, head_c;
    logic [WW-1:0] want_in, have_w;
    logic [WW-1:0] rest_w;
    logic [GW-1:0] rest;
    logic [PW-1:0] off_w;
    logic          ignore;
    logic [GW-1:0] pg_in;
    logic [EW-1:0] end_pg, end_cp;
    logic          merge_n;
    logic [SW-1:0] new_ps;
    logic [LW-1:0] new_lk;
    logic [31:0]   grant_w;

    assign rd_link = (rd_link_raw >= LIST_END) ? LIST_END : rd_link_raw;
    assign head_c  = (head_reg >= LIST_END) ? LIST_END : head_reg;
    assign want_in = ((WW'(in_bytes) + WW'(GRANULE_BYTES - 1)) >> GL) + WW'(1) << GL;
    assign have_w  = WW'(rd_size);
    assign rest_w  = WW'(np_reg) + (want_reg >> GL);
    assign rest    = rest_w[GW-1:0];
    assign off_w   = PW'(in_off);
    assign ignore  = (in_off == '0) || (off_w >= PW'(POOL_BYTES - GRANULE_BYTES))
                     || (in_off[GL-1:0] != '0);
    assign pg_in   = GW'((in_off >> GL) - OFF_W'(1));
    assign end_pg  = EW'(pg_reg) + EW'(ps_reg >> GL);
    assign end_cp  = EW'(cp_reg) + EW'(cps_reg >> GL);
    assign merge_n = (np_reg != LIST_END) && (end_pg == EW'(np_reg));
    assign new_ps  = merge_n ? ps_reg + ns_reg : ps_reg;
    assign new_lk  = merge_n ? nl_reg : np_reg;
    assign grant_w = (32'(np_reg) + 32'd1) << GL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_head_reg <= cp_head_next;
        cp_reg      <= cp_next;
        np_reg      <= np_next;
        pg_reg      <= pg_next;
        want_reg    <= want_next;
        ps_reg      <= ps_next;
        ns_reg      <= ns_next;
        cps_reg     <= cps_next;
        nl_reg      <= nl_next;
        res_reg     <= res_next;
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        cp_head_next = cp_head_reg;
        cp_next      = cp_reg;
        np_next      = np_reg;
        pg_next      = pg_reg;
        want_next    = want_reg;
        ps_next      = ps_reg;
        ns_next      = ns_reg;
        cps_next     = cps_reg;
        nl_next      = nl_reg;
        res_next     = res_reg;
        req          = '0;
        in_ready     = (state_reg == S_IDLE);
        res_valid    = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE: begin
                res_next.offset = '0;
                res_next.status = ST_DONE;
                np_next         = head_c;
                cp_head_next    = 1'b1;
                want_next       = want_in;
                pg_next         = pg_in;
                if (in_valid) begin
                    if (in_cmd == CMD_ALLOC) begin
                        if (in_bytes == '0) begin
                            res_next.status = ST_ZERO;
                            state_next      = S_OUT;
                        end else if (head_c == LIST_END) begin
                            res_next.status = ST_NO_MEM;
                            state_next      = S_OUT;
                        end else begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = head_c[GW-1:0];
                            state_next  = S_A_WALK;
                        end
                    end else if (ignore) begin
                        res_next.status = ST_IGNORED;
                        state_next      = S_OUT;
                    end else if (head_c < LW'(pg_in)) begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = head_c[GW-1:0];
                        state_next  = S_F_WALK;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = pg_in;
                        state_next  = S_F_PGD;
                    end
                end
            end
            S_A_WALK: begin
                if (have_w >= want_reg) begin
                    res_next.offset = grant_w[OFF_W-1:0];
                    if (want_reg + WW'(GRANULE_BYTES) >= have_w) begin
                        // use the block whole: unlink it
                        if (cp_head_reg) begin
                            head_next = rd_link;
                        end else begin
                            req.lk_we    = 1'b1;
                            req.lk_addr  = cp_reg;
                            req.lk_wdata = rd_link;
                        end
                        state_next = S_OUT;
                    end else begin
                        req.sz_we    = 1'b1;
                        req.sz_addr  = rest;
                        req.sz_wdata = SW'(have_w - want_reg);
                        req.lk_we    = 1'b1;
                        req.lk_addr  = rest;
                        req.lk_wdata = rd_link;
                        state_next   = S_A_SPLIT;
                    end
                end else begin
                    cp_next      = np_reg[GW-1:0];
                    cp_head_next = 1'b0;
                    np_next      = rd_link;
                    if (rd_link == LIST_END) begin
                        res_next.status = ST_NO_MEM;
                        state_next      = S_OUT;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = rd_link[GW-1:0];
                    end
                end
            end
            S_A_SPLIT: begin
                if (cp_head_reg) begin
                    head_next = LW'(rest);
                end else begin
                    req.lk_we    = 1'b1;
                    req.lk_addr  = cp_reg;
                    req.lk_wdata = LW'(rest);
                end
                req.sz_we    = 1'b1;
                req.sz_addr  = np_reg[GW-1:0];
                req.sz_wdata = SW'(want_reg);
                state_next   = S_OUT;
            end
            S_F_WALK: begin
                cp_next      = np_reg[GW-1:0];
                cps_next     = rd_size;
                cp_head_next = 1'b0;
                np_next      = rd_link;
                req.rd_en    = 1'b1;
                if (rd_link < LW'(pg_reg)) begin
                    req.rd_addr = rd_link[GW-1:0];
                end else begin
                    req.rd_addr = pg_reg;
                    state_next  = S_F_PGD;
                end
            end
            S_F_PGD: begin
                ps_next = rd_size;
                if (np_reg != LIST_END) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = np_reg[GW-1:0];
                    state_next  = S_F_NPD;
                end else begin
                    ns_next    = '0;
                    nl_next    = LIST_END;
                    state_next = S_F_WNEXT;
                end
            end
            S_F_NPD: begin
                ns_next    = rd_size;
                nl_next    = rd_link;
                state_next = S_F_WNEXT;
            end
            S_F_WNEXT: begin
                req.sz_we    = 1'b1;
                req.sz_addr  = pg_reg;
                req.sz_wdata = new_ps;
                req.lk_we    = 1'b1;
                req.lk_addr  = pg_reg;
                req.lk_wdata = new_lk;
                ps_next      = new_ps;
                nl_next      = new_lk;
                state_next   = S_F_WPREV;
            end
            S_F_WPREV: begin
                if (!cp_head_reg && end_cp == EW'(pg_reg)) begin
                    req.sz_we    = 1'b1;
                    req.sz_addr  = cp_reg;
                    req.sz_wdata = cps_reg + ps_reg;
                    req.lk_we    = 1'b1;
                    req.lk_addr  = cp_reg;
                    req.lk_wdata = nl_reg;
                end else if (cp_head_reg) begin
                    head_next = LW'(pg_reg);
                end else begin
                    req.lk_we    = 1'b1;
                    req.lk_addr  = cp_reg;
                    req.lk_wdata = LW'(pg_reg);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res = res_reg;
endmodule
`default_nettype wire

/* hdl/first_fit_pool_allocator_core.sv */
// Top level of the first-fit pool allocator: stream ports and result register.
// Depends on ffpa_pkg, ffpa_store and ffpa_ctrl.
//
// Usage: each input word is one command. s_tuser carries the command (0
// allocate, 1 free); s_tdata carries request_bytes and release_offset.
// Each command yields exactly one result word: m_tuser is the status
// (0 done, 1 zero size, 2 out of memory, 3 free ignored), m_tdata the
// granted offset just past the block header, 0 when nothing is granted.
// Commands are handled one at a time. An allocate visits the free blocks in
// list order up to the first fit and splits that block when more than one
// granule would remain. A free walks the free blocks below the released one,
// then merges it with free neighbours. A rejected command goes straight out.
// Walks read one list node per cycle from the size and link memories.
// The result sits in an output register; the next command is taken while it
// waits. A stalled receiver holds the result and, once the next one is
// ready, stops intake. Reset makes the whole pool one free block at granule 0;
// no clearing pass is needed.
`default_nettype none
module first_fit_pool_allocator_core import ffpa_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [16:0] request_bytes, [32:17] release_offset
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] granted_offset
    output logic [1:0]       m_tuser    // [1:0] status
);
    mem_req_t      req;
    logic [SW-1:0] rd_size;
    logic [LW-1:0] rd_link;
    logic          res_valid, res_ready;
    result_t       res;
    logic          m_valid_reg;
    result_t       m_res_reg;
    cmd_t          in_cmd;

    assign in_cmd = cmd_t'(s_tuser);

    ffpa_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_size (rd_size),
        .rd_link (rd_link)
    );

    ffpa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (in_cmd),
        .in_bytes    (s_tdata[16:0]),
        .in_off      (s_tdata[32:17]),
        .req         (req),
        .rd_size     (rd_size),
        .rd_link_raw (rd_link),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Load a finished result when the output register is empty or draining.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.offset;
    assign m_tuser  = m_res_reg.status;
endmodule
`default_nettype wire
